// ===== hw/rtl/sabs_pkg.sv =====
// ----------------------------------------------------------------------------
// sabs_pkg
// Shared types, constants and helpers for the sorted array binary search block.
// ----------------------------------------------------------------------------
package sabs_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SE_W       = CNT_W + 1;   // signed search bounds, down to -1
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 10;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_SEARCH = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_ANY   = 2'd0,
        MODE_FIRST = 2'd1,
        MODE_LAST  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_cmd                  cmd;
        logic [DATA_WIDTH-1:0] value;
    } t_item;

    // Keep the low min(32, DATA_WIDTH) bits, sign extended to DATA_WIDTH.
    function automatic logic [DATA_WIDTH-1:0] to_word(input logic [VALUE_W-1:0] raw);
        logic [DATA_WIDTH-1:0] w;
        w = '0;
        for (int i = 0; i < DATA_WIDTH; i++) begin
            w[i] = (i < VALUE_W) ? raw[i] : raw[VALUE_W-1];
        end
        return w;
    endfunction

    // Report an index in its low POS_W bits.
    function automatic logic [POS_W-1:0] to_pos(input logic [ADDR_W-1:0] a);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < POS_W; i++) begin
            p[i] = (i < ADDR_W) ? a[i] : 1'b0;
        end
        return p;
    endfunction

endpackage

// ===== hw/rtl/sabs_ram.sv =====
// ----------------------------------------------------------------------------
// sabs_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sabs_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sabs_queue.sv =====
// ----------------------------------------------------------------------------
// sabs_queue
// Two-entry FIFO of decoded commands between the front and the back end.
// ----------------------------------------------------------------------------
module sabs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sabs_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output sabs_pkg::t_item o_item
);
    import sabs_pkg::*;

    t_item       r_entry [2];
    logic        r_wptr, n_wptr;
    logic        r_rptr, n_rptr;
    logic [1:0]  r_fill, n_fill;
    logic        w_push, w_pop;

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign o_item  = r_entry[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wptr = w_push ? ~r_wptr : r_wptr;
        n_rptr = w_pop  ? ~r_rptr : r_rptr;
        n_fill = r_fill + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wptr] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/sabs_front.sv =====
// ----------------------------------------------------------------------------
// sabs_front
// Input stage: accept transactions, drop unused commands, queue the rest.
// ----------------------------------------------------------------------------
module sabs_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [sabs_pkg::IN_DATA_W-1:0]   i_data,
    output logic                             o_push,
    output sabs_pkg::t_item                  o_item,
    input  logic                             i_full
);
    import sabs_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item;
    logic  w_keep;
    logic  w_take;

    always_comb begin
        case (i_data[1:0])
            CMD_APPEND, CMD_CLEAR, CMD_SEARCH: w_keep = 1'b1;
            default:                           w_keep = 1'b0;
        endcase
    end

    assign o_ready = !r_valid || !i_full;
    assign w_take  = i_valid && o_ready;
    assign o_push  = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (r_valid && !i_full) begin
            n_valid = 1'b0;
        end
        // drop the unused command code here, it never reaches the back end
        if (w_take && w_keep) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_keep) begin
            r_item.cmd   <= t_cmd'(i_data[1:0]);
            r_item.value <= to_word(i_data[VALUE_W+1:2]);
        end
    end

endmodule

// ===== hw/rtl/sabs_back.sv =====
// ----------------------------------------------------------------------------
// sabs_back
// Execution engine: appends, clears and binary searches over the store.
// ----------------------------------------------------------------------------
module sabs_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_wdata,
    input  logic                           i_empty,
    input  sabs_pkg::t_item                i_item,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_found,
    output logic [sabs_pkg::POS_W-1:0]     o_position
);
    import sabs_pkg::*;

    t_state                   r_state, n_state;
    logic [1:0]               r_mode;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [DATA_WIDTH-1:0]    r_key, n_key;
    logic signed [SE_W-1:0]   r_s, n_s;
    logic signed [SE_W-1:0]   r_e, n_e;
    logic [ADDR_W-1:0]        r_mid, n_mid;
    logic                     r_hit, n_hit;
    logic [ADDR_W-1:0]        r_pos, n_pos;
    logic                     r_ovalid, n_ovalid;
    logic                     r_found, n_found;
    logic [POS_W-1:0]         r_opos, n_opos;

    logic                     w_we;
    logic [DATA_WIDTH-1:0]    w_rdata;
    logic signed [SE_W-1:0]   w_mid;
    logic signed [SE_W-1:0]   w_mid_s;
    logic                     w_out_free;

    assign w_mid   = r_s + ((r_e - r_s) >>> 1);
    assign w_mid_s = $signed({{(SE_W-ADDR_W){1'b0}}, r_mid});
    assign w_out_free = !r_ovalid || i_ready;

    sabs_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_item.value),
        .i_raddr (w_mid[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_key    = r_key;
        n_s      = r_s;
        n_e      = r_e;
        n_mid    = r_mid;
        n_hit    = r_hit;
        n_pos    = r_pos;
        n_ovalid = r_ovalid;
        n_found  = r_found;
        n_opos   = r_opos;
        o_pop    = 1'b0;
        w_we     = 1'b0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_item.cmd)
                        CMD_APPEND: begin
                            // ignore appends to a full store
                            if (r_count < CNT_W'(DEPTH)) begin
                                w_we    = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_SEARCH: begin
                            n_key   = i_item.value;
                            n_s     = '0;
                            n_e     = $signed({1'b0, r_count}) - SE_W'(1);
                            n_hit   = 1'b0;
                            n_pos   = '0;
                            n_state = ST_PROBE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                // the read at w_mid is issued this cycle, data arrives in ST_CMP
                if (r_s <= r_e) begin
                    n_mid   = w_mid[ADDR_W-1:0];
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_CMP: begin
                n_state = ST_PROBE;
                if (w_rdata == r_key) begin
                    n_hit = 1'b1;
                    n_pos = r_mid;
                    case (r_mode)
                        MODE_FIRST: n_e = w_mid_s - SE_W'(1);
                        MODE_LAST:  n_s = w_mid_s + SE_W'(1);
                        default:    n_state = ST_OUT;
                    endcase
                end else if ($signed(w_rdata) > $signed(r_key)) begin
                    n_e = w_mid_s - SE_W'(1);
                end else begin
                    n_s = w_mid_s + SE_W'(1);
                end
            end
            ST_OUT: begin
                // hold the result until the output register frees up
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_found  = r_hit;
                    n_opos   = r_hit ? to_pos(r_pos) : '0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_mode   <= MODE_ANY;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_s     <= n_s;
        r_e     <= n_e;
        r_mid   <= n_mid;
        r_hit   <= n_hit;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_opos  <= n_opos;
    end

    assign o_valid    = r_ovalid;
    assign o_found    = r_found;
    assign o_position = r_opos;

    a_cmp_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CMP |-> $past(r_state) == ST_PROBE)
        else $error("compare step without a preceding probe");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count beyond store depth");

    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_found |-> r_opos == '0)
        else $error("nonzero position on a miss");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |=> r_count == $past(r_count))
        else $error("element count changed during a search");

endmodule

// ===== hw/rtl/sorted_array_binary_search.sv =====
// Append and clear: the store is updated behind the front register and the queue, no result.
// Search: each probe is a registered store read (ST_PROBE), then a compare (ST_CMP), up to
// floor(log2(count))+1 probes, between entry from ST_IDLE and exit through ST_OUT.
// A search holds the back end until its result is registered; a 2-entry command
// queue lets input transactions stack up behind it.
// Reset clears the element count, search mode and queue; the store keeps data.
// ----------------------------------------------------------------------------
// sorted_array_binary_search
// Element store with append, clear and any/first/last binary search.
// ----------------------------------------------------------------------------
module sorted_array_binary_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_wdata,     // search_mode
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sabs_pkg::IN_DATA_W-1:0]    s_axis_tdata,    // command[1:0], value[33:2]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sabs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,    // position[9:0]
    output logic                              m_axis_tuser     // found
);
    import sabs_pkg::*;

    logic       w_push;
    t_item      w_front_item;
    logic       w_full;
    logic       w_pop;
    logic       w_empty;
    t_item      w_queue_item;
    logic [POS_W-1:0] w_position;

    sabs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_push  (w_push),
        .o_item  (w_front_item),
        .i_full  (w_full)
    );

    sabs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_queue_item)
    );

    sabs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_empty     (w_empty),
        .i_item      (w_queue_item),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_found     (m_axis_tuser),
        .o_position  (w_position)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-POS_W){1'b0}}, w_position};

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the sorted array binary search block. Commands go in
// through the input stream; a scoreboard mirrors the element store and search
// mode, predicts every search answer, and checks the output stream in order.
// ----------------------------------------------------------------------------
module tb;
    import sabs_pkg::*;

    localparam logic [1:0]        CMD_UNUSED    = 2'd3;
    localparam logic [1:0]        MODE_UNUSED   = 2'd3;
    localparam int                SETTLE_CYCLES = 40;
    localparam int                STALL_LIMIT   = 4000;
    localparam int                REPORT_MAX    = 10;
    localparam int                HOLD_CYCLES   = 400;
    localparam logic signed [31:0] VAL_MIN      = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX      = 32'sh7fff_ffff;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } t_search_answer;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    // mirror of the block state
    logic signed [31:0]    elem_mem [0:DEPTH-1];
    int                    elem_cnt;
    logic [1:0]            mode_now;
    t_search_answer        answers_q[$];

    int                    mismatch_cnt;
    int                    sent_items;
    int                    tx_idle_pct;
    int                    rx_idle_pct;
    int                    hold_left;
    int                    quiet_cycles;

    sorted_array_binary_search uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // command[1:0], value[33:2]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // position[9:0]
        .m_axis_tuser  (m_axis_tuser)    // found
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_search_answer search_answer(input logic signed [31:0] key);
        t_search_answer ans;
        int             lo;
        int             hi;
        int             mid;
        bit             done;
        ans  = '0;
        lo   = 0;
        hi   = elem_cnt - 1;
        done = 1'b0;
        while (!done && lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (elem_mem[mid] == key) begin
                ans.found = 1'b1;
                ans.pos   = mid[POS_W-1:0];
                if (mode_now == MODE_FIRST) begin
                    hi = mid - 1;
                end else if (mode_now == MODE_LAST) begin
                    lo = mid + 1;
                end else begin
                    done = 1'b1;
                end
            end else if (elem_mem[mid] > key) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return ans;
    endfunction

    function automatic void mirror_command(input logic [1:0] cmd, input logic signed [31:0] val);
        case (cmd)
            CMD_APPEND: begin
                if (elem_cnt < DEPTH) begin
                    elem_mem[elem_cnt] = val;
                    elem_cnt++;
                end
            end
            CMD_CLEAR:  elem_cnt = 0;
            CMD_SEARCH: answers_q.push_back(search_answer(val));
            default: ;
        endcase
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endfunction

    // ------------------------------------------------------------------
    // output side: random stalls plus a long hold on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left     = hold_left - 1;
        end else begin
            m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_search_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answers_q.size() == 0) begin
                note_mismatch($sformatf("unexpected transaction found=%0b position=%0d",
                                        m_axis_tuser, m_axis_tdata[POS_W-1:0]));
            end else begin
                want = answers_q.pop_front();
                if (m_axis_tuser !== want.found) begin
                    note_mismatch($sformatf("found: expected %0b, got %0b",
                                            want.found, m_axis_tuser));
                end
                if (m_axis_tdata[POS_W-1:0] !== want.pos) begin
                    note_mismatch($sformatf("position: expected %0d, got %0d",
                                            want.pos, m_axis_tdata[POS_W-1:0]));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[sorted_array_binary_search] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // input side helpers
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(IN_DATA_W-34){1'b0}}, val, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        mirror_command(cmd, val);
        if (cmd != CMD_UNUSED) sent_items++;
    endtask

    // Drain every pending answer, then give trailing appends time to retire.
    task automatic wait_quiet();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (answers_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        wait_quiet();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = m;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        mode_now    = m;
    endtask

    function automatic logic signed [31:0] pick_key();
        logic signed [31:0] elem;
        int                 sel;
        sel  = $urandom_range(9);
        elem = (elem_cnt > 0) ? elem_mem[$urandom_range(elem_cnt - 1)] : $urandom;
        case (sel)
            5:       return elem + 1;
            6:       return elem - 1;
            7:       return $urandom;
            8:       return VAL_MIN;
            9:       return VAL_MAX;
            default: return elem;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_empty_store();
        send_item(CMD_SEARCH, 32'sd0);
        send_item(CMD_SEARCH, VAL_MIN);
        send_item(CMD_UNUSED, 32'sd0);
        send_item(CMD_SEARCH, 32'sd0);
    endtask

    task automatic test_extremes();
        send_item(CMD_CLEAR, 32'sd0);
        send_item(CMD_APPEND, VAL_MIN);
        send_item(CMD_APPEND, -32'sd1);
        send_item(CMD_APPEND, 32'sd0);
        send_item(CMD_APPEND, VAL_MAX);
        send_item(CMD_SEARCH, VAL_MIN);
        send_item(CMD_SEARCH, VAL_MAX);
        send_item(CMD_SEARCH, -32'sd1);
        send_item(CMD_SEARCH, 32'sd1);
    endtask

    task automatic test_duplicates();
        logic [1:0] modes [4];
        modes = '{MODE_FIRST, MODE_LAST, MODE_UNUSED, MODE_ANY};
        send_item(CMD_CLEAR, 32'sd0);
        repeat (3) send_item(CMD_APPEND, 32'sd5);
        repeat (4) send_item(CMD_APPEND, 32'sd9);
        foreach (modes[i]) begin
            set_mode(modes[i]);
            send_item(CMD_SEARCH, 32'sd5);
            send_item(CMD_SEARCH, 32'sd9);
        end
        send_item(CMD_SEARCH, 32'sd7);
    endtask

    // Fill every entry, then push one more append that must be dropped.
    task automatic test_full_store();
        send_item(CMD_CLEAR, 32'sd0);
        for (int i = 0; i < DEPTH; i++) send_item(CMD_APPEND, i * 4 - 2048);
        send_item(CMD_APPEND, VAL_MAX);
        send_item(CMD_SEARCH, VAL_MAX);
        set_mode(MODE_LAST);
        send_item(CMD_SEARCH, 32'sd2044);
        set_mode(MODE_FIRST);
        send_item(CMD_SEARCH, -32'sd2048);
        send_item(CMD_SEARCH, 32'sd2);
    endtask

    task automatic test_random(input int n_items);
        int                 goal;
        int                 n;
        int                 r;
        int                 step_max;
        longint             acc;
        logic signed [31:0] seed_val;
        goal = sent_items + n_items;
        while (sent_items < goal) begin
            if ($urandom_range(3) == 0) set_mode(2'($urandom_range(3)));
            if ($urandom_range(99) < 10) begin
                // noise: any command, unsorted values
                repeat ($urandom_range(1, 8)) send_item(2'($urandom_range(3)), $urandom);
            end else begin
                if ($urandom_range(9) != 0) send_item(CMD_CLEAR, $urandom);
                r = $urandom_range(99);
                n = (r < 85) ? $urandom_range(1, 24) :
                    (r < 97) ? $urandom_range(25, 120) : $urandom_range(121, 400);
                seed_val = $urandom;
                case ($urandom_range(2))
                    0: begin
                        step_max = 2;
                        acc      = longint'(int'($urandom_range(40))) - 20;
                    end
                    1: begin
                        step_max = 1000;
                        acc      = seed_val;
                    end
                    default: begin
                        step_max = 1 << 28;
                        acc      = longint'(VAL_MIN) + $urandom_range(1 << 20);
                    end
                endcase
                repeat (n) begin
                    send_item(CMD_APPEND, acc[31:0]);
                    acc = acc + $urandom_range(step_max);
                    if (acc > longint'(VAL_MAX)) acc = VAL_MAX;
                end
                repeat ($urandom_range(1, 6)) send_item(CMD_SEARCH, pick_key());
            end
        end
    endtask

    // Stall the output long enough for the command queue to back up.
    task automatic test_backpressure();
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        repeat (16) send_item(CMD_SEARCH, pick_key());
        wait_quiet();
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 2'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        elem_cnt      = 0;
        mode_now      = MODE_ANY;
        mismatch_cnt  = 0;
        sent_items    = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        tx_idle_pct   = 6;
        rx_idle_pct   = 51;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_store();
        test_extremes();
        test_duplicates();
        test_full_store();
        test_random(140);

        tx_idle_pct = 51;
        rx_idle_pct = 6;
        test_random(140);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_backpressure();
        test_random(140);

        set_mode(MODE_UNUSED);
        send_item(CMD_SEARCH, pick_key());
        wait_quiet();

        if (mismatch_cnt == 0 && answers_q.size() == 0) begin
            $display("[sorted_array_binary_search] OK");
        end else begin
            $display("[sorted_array_binary_search] ERROR");
        end
        $finish;
    end

endmodule
